/* rtl/rne_pkg.sv */
// Shared types, constants and lookup functions of the Roman numeral encoder.
// Used by rne_ctrl, rne_datapath, roman_numeral_encoder, roman_numeral_checker and tb; depends on nothing.
package rne_pkg;

    localparam int unsigned C_MAX_NUMBER = 3999;

    // Digit positions, also used as the split step index.
    localparam logic [1:0] C_POS_THOUSANDS = 2'd0;
    localparam logic [1:0] C_POS_HUNDREDS  = 2'd1;
    localparam logic [1:0] C_POS_TENS      = 2'd2;
    localparam logic [1:0] C_POS_ONES      = 2'd3;

    localparam logic [7:0] C_CHAR_M = 8'h4D;
    localparam logic [7:0] C_CHAR_D = 8'h44;
    localparam logic [7:0] C_CHAR_C = 8'h43;
    localparam logic [7:0] C_CHAR_L = 8'h4C;
    localparam logic [7:0] C_CHAR_X = 8'h58;
    localparam logic [7:0] C_CHAR_V = 8'h56;
    localparam logic [7:0] C_CHAR_I = 8'h49;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPLIT,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CAP   = 2'd2
    } t_status;

    // Role of a letter within one decimal digit: unit, five or next unit.
    typedef enum logic [1:0] {
        K_ONE,
        K_FIVE,
        K_TEN
    } t_kind;

    typedef struct packed {
        logic       load;
        logic       split;
        logic [1:0] step;
        logic       check;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic done_item;
    } t_sts;

    // Number of letters that one decimal digit needs.
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        unique case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Role of letter k of digit d.
    function automatic t_kind letter_kind(input logic [3:0] d, input logic [1:0] k);
        t_kind r;
        unique case (d)
            4'd4:                r = (k == 2'd0) ? K_ONE : K_FIVE;
            4'd5:                r = K_FIVE;
            4'd6, 4'd7, 4'd8:    r = (k == 2'd0) ? K_FIVE : K_ONE;
            4'd9:                r = (k == 2'd0) ? K_ONE : K_TEN;
            default:             r = K_ONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] roman_char(input logic [1:0] pos, input t_kind kind);
        logic [7:0] c;
        unique case (pos)
            C_POS_THOUSANDS: c = C_CHAR_M;
            C_POS_HUNDREDS:  c = (kind == K_ONE) ? C_CHAR_C :
                                 (kind == K_FIVE) ? C_CHAR_D : C_CHAR_M;
            C_POS_TENS:      c = (kind == K_ONE) ? C_CHAR_X :
                                 (kind == K_FIVE) ? C_CHAR_L : C_CHAR_C;
            default:         c = (kind == K_ONE) ? C_CHAR_I :
                                 (kind == K_FIVE) ? C_CHAR_V : C_CHAR_X;
        endcase
        return c;
    endfunction

endpackage

/* rtl/roman_numeral_encoder.sv */
// Top level of the Roman numeral encoder: joins the controller and the datapath.
// Depends on rne_pkg, rne_ctrl and rne_datapath.
//
// Converts a signed 16-bit number to its Roman numeral (M, CM, D, CD, C, XC, L,
// XL, X, IX, V, IV, I) and sends it out one ASCII letter per transaction, most
// significant letter first, with o_last on the final one. Every letter carries
// the whole numeral's letter count. A number outside 0 to 3999 gives a single
// out-of-range result; a numeral that does not fit the capacity together with
// its terminator gives a single too-small result; zero gives a single ok result
// with no letter. The block works on one number at a time: after acceptance it
// splits the number into decimal digits in split steps for the thousands,
// hundreds and tens, the ones digit being what remains, then counts letters and
// checks the capacity, then produces one result per cycle into its output
// register while the output is not stalled. The next number is accepted while
// the final result still waits in the output register.
module roman_numeral_encoder
    import rne_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_number,
    input  logic        [7:0]  i_capacity,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic        [7:0]  o_symbol,
    output logic               o_symbol_valid,
    output logic        [1:0]  o_status,
    output logic        [3:0]  o_total_length,
    output logic               o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    rne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    rne_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_number       (i_number),
        .i_capacity     (i_capacity),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_symbol       (o_symbol),
        .o_symbol_valid (o_symbol_valid),
        .o_status       (o_status),
        .o_total_length (o_total_length),
        .o_last         (o_last)
    );

endmodule

/* rtl/rne_ctrl.sv */
// Controller of the Roman numeral encoder: sequences load, digit split,
// length check and letter emission. Depends on rne_pkg.
module rne_ctrl
    import rne_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= C_POS_THOUSANDS;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = C_POS_THOUSANDS;
                    n_state    = S_SPLIT;
                end
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                if (r_step == C_POS_TENS) begin
                    n_state = S_CHECK;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.done_item) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_starts_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SPLIT && r_step == C_POS_THOUSANDS))
        else $error("accepted transaction did not start the digit split");

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.done_item) |=> o_in_ready)
        else $error("block not ready after the final result of a transaction");

endmodule

/* rtl/rne_datapath.sv */
// Datapath of the Roman numeral encoder: digit split, letter count, capacity
// check, letter sequencing and the output register. Depends on rne_pkg.
module rne_datapath
    import rne_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [15:0] i_number,
    input  logic        [7:0]  i_capacity,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic        [7:0]  o_symbol,
    output logic               o_symbol_valid,
    output logic        [1:0]  o_status,
    output logic        [3:0]  o_total_length,
    output logic               o_last
);

    logic [11:0] r_value;
    logic [7:0]  r_cap;
    logic        r_err_range;
    logic        r_err_cap;
    logic [3:0]  r_len;
    logic [3:0]  r_d [4];
    logic [1:0]  r_pos;
    logic [1:0]  r_k;

    logic        r_out_valid;
    logic [7:0]  r_out_symbol;
    logic        r_out_symbol_valid;
    t_status     r_out_status;
    logic [3:0]  r_out_total;
    logic        r_out_last;

    logic [13:0] w_thr;
    logic [13:0] w_sub;
    logic [3:0]  w_dig;
    logic [11:0] w_rem;
    logic [2:0]  w_dlen [4];
    logic [4:0]  w_sum;
    logic [1:0]  w_first;
    logic [1:0]  w_next_pos;
    logic        w_next_found;
    logic        w_dig_end;
    logic        w_letter_last;
    logic [7:0]  w_char;
    logic        w_letters;
    logic        w_range;

    assign w_range = i_number[15] || (i_number[14:0] > 15'(C_MAX_NUMBER));

    // One decimal digit per split step: the largest multiple of the step's
    // scale that does not exceed the remaining value.
    always_comb begin
        w_dig = 4'd0;
        w_sub = 14'd0;
        w_thr = 14'd0;
        for (int k = 1; k < 10; k++) begin
            case (i_cmd.step)
                C_POS_THOUSANDS: w_thr = 14'(k * 1000);
                C_POS_HUNDREDS:  w_thr = 14'(k * 100);
                default:         w_thr = 14'(k * 10);
            endcase
            if ({2'b00, r_value} >= w_thr) begin
                w_dig = 4'(k);
                w_sub = w_thr;
            end
        end
        w_rem = 12'({2'b00, r_value} - w_sub);
    end

    always_comb begin
        w_sum        = 5'd0;
        w_first      = C_POS_ONES;
        w_next_pos   = C_POS_ONES;
        w_next_found = 1'b0;
        for (int i = 0; i < 4; i++) begin
            w_dlen[i] = digit_len(r_d[i]);
            w_sum     = w_sum + 5'(w_dlen[i]);
        end
        for (int i = 3; i >= 0; i--) begin
            if (w_dlen[i] != 3'd0) begin
                w_first = 2'(i);
            end
            if (w_dlen[i] != 3'd0 && 2'(i) > r_pos) begin
                w_next_pos   = 2'(i);
                w_next_found = 1'b1;
            end
        end
    end

    assign w_char        = roman_char(r_pos, letter_kind(r_d[r_pos], r_k));
    assign w_dig_end     = ({1'b0, r_k} + 3'd1) == w_dlen[r_pos];
    assign w_letter_last = w_dig_end && !w_next_found;
    assign w_letters     = !r_err_range && !r_err_cap && (r_len != 4'd0);

    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_sts.done_item = !w_letters || w_letter_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value     <= i_number[11:0];
            r_cap       <= i_capacity;
            r_err_range <= w_range;
        end
        if (i_cmd.split) begin
            r_d[i_cmd.step] <= w_dig;
            r_value         <= w_rem;
            if (i_cmd.step == C_POS_TENS) begin
                r_d[C_POS_ONES] <= w_rem[3:0];
            end
        end
        if (i_cmd.check) begin
            r_len     <= w_sum[3:0];
            r_err_cap <= {3'b000, w_sum} >= r_cap;
            r_pos     <= w_first;
            r_k       <= 2'd0;
        end
        if (i_cmd.emit && w_letters) begin
            if (w_dig_end) begin
                r_pos <= w_next_pos;
                r_k   <= 2'd0;
            end else begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_symbol       <= 8'd0;
            r_out_symbol_valid <= 1'b0;
            r_out_total        <= 4'd0;
            r_out_last         <= 1'b1;
            if (r_err_range) begin
                r_out_status <= ST_RANGE;
            end else if (r_err_cap) begin
                r_out_status <= ST_CAP;
            end else begin
                r_out_status <= ST_OK;
                if (w_letters) begin
                    r_out_symbol       <= w_char;
                    r_out_symbol_valid <= 1'b1;
                    r_out_total        <= r_len;
                    r_out_last         <= w_letter_last;
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_out_symbol;
    assign o_symbol_valid = r_out_symbol_valid;
    assign o_status       = r_out_status;
    assign o_total_length = r_out_total;
    assign o_last         = r_out_last;

    a_letter_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_symbol_valid) |-> (o_status == ST_OK && o_total_length != 4'd0))
        else $error("letter result without ok status or letter count");

    a_error_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK)
            |-> (o_last && !o_symbol_valid && o_total_length == 4'd0))
        else $error("error result is not a lone status-only result");

    a_letter_in_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && w_letters)
            |-> (w_dlen[r_pos] != 3'd0 && {1'b0, r_k} < w_dlen[r_pos]))
        else $error("letter sequencer points past the current digit");

endmodule

/* tb/sv/roman_numeral_checker.sv */
`timescale 1ns / 1ps
// Checker for the Roman numeral encoder: watches both channels, predicts the letters
// of every accepted number and compares each result transaction field by field.
// Depends on rne_pkg for the status codes, the letter codes and the largest number.
module roman_numeral_checker
    import rne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_number,
    input  logic [7:0]  i_capacity,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_symbol,
    input  logic        i_symbol_valid,
    input  logic [1:0]  i_status,
    input  logic [3:0]  i_total_length,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_items,
    output int          o_range_items,
    output int          o_cap_items,
    output int          o_letters
);

    localparam int C_MAX_LETTERS = 15;

    // Greedy table, largest step at the highest index. The upper byte of a text
    // entry is the first letter, and a zero lower byte means a single letter.
    localparam logic [12:0][11:0] C_STEP_WEIGHT = {
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };
    localparam logic [12:0][15:0] C_STEP_TEXT = {
        {C_CHAR_M, 8'h00}, {C_CHAR_C, C_CHAR_M}, {C_CHAR_D, 8'h00},
        {C_CHAR_C, C_CHAR_D}, {C_CHAR_C, 8'h00}, {C_CHAR_X, C_CHAR_C},
        {C_CHAR_L, 8'h00}, {C_CHAR_X, C_CHAR_L}, {C_CHAR_X, 8'h00},
        {C_CHAR_I, C_CHAR_X}, {C_CHAR_V, 8'h00}, {C_CHAR_I, C_CHAR_V},
        {C_CHAR_I, 8'h00}
    };

    typedef struct packed {
        logic [7:0] symbol;
        logic       symbol_valid;
        t_status    status;
        logic [3:0] total_length;
        logic       last;
    } t_numeral_result;

    t_numeral_result numeral_q[$];
    int err_count    = 0;
    int item_count   = 0;
    int range_count  = 0;
    int cap_count    = 0;
    int letter_count = 0;

    function automatic void push_status_only(input t_status st);
        t_numeral_result res;
        res.symbol       = 8'h00;
        res.symbol_valid = 1'b0;
        res.status       = st;
        res.total_length = 4'd0;
        res.last         = 1'b1;
        numeral_q.push_back(res);
    endfunction

    function automatic void predict_numeral(input logic [15:0] number,
                                            input logic [7:0] capacity);
        logic [7:0]      letters [0:C_MAX_LETTERS-1];
        int unsigned     count;
        int unsigned     rest;
        int              step;
        t_numeral_result res;
        count = 0;
        // A negative number has its sign bit set, so it also lands above the limit.
        if (number > C_MAX_NUMBER) begin
            push_status_only(ST_RANGE);
            range_count++;
            return;
        end
        rest = {16'h0000, number};
        for (step = 12; step >= 0; step--) begin
            while (rest >= C_STEP_WEIGHT[step] && count < C_MAX_LETTERS) begin
                letters[count] = C_STEP_TEXT[step][15:8];
                count++;
                if (C_STEP_TEXT[step][7:0] != 8'h00 && count < C_MAX_LETTERS) begin
                    letters[count] = C_STEP_TEXT[step][7:0];
                    count++;
                end
                rest -= C_STEP_WEIGHT[step];
            end
        end
        // The buffer must also hold the terminator.
        if (capacity < count + 1) begin
            push_status_only(ST_CAP);
            cap_count++;
        end else if (count == 0) begin
            push_status_only(ST_OK);
        end else begin
            for (step = 0; step < count; step++) begin
                res.symbol       = letters[step];
                res.symbol_valid = 1'b1;
                res.status       = ST_OK;
                res.total_length = count[3:0];
                res.last         = (step == count - 1);
                numeral_q.push_back(res);
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_numeral_result want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (numeral_q.size() == 0) begin
                    $error("result with no number pending: symbol 'h%02h, status %0d",
                           i_symbol, i_status);
                    err_count++;
                end else begin
                    want = numeral_q.pop_front();
                    if (i_symbol !== want.symbol) begin
                        $error("symbol: expected 'h%02h, actual 'h%02h",
                               want.symbol, i_symbol);
                        err_count++;
                    end
                    if (i_symbol_valid !== want.symbol_valid) begin
                        $error("symbol_valid: expected %0b, actual %0b",
                               want.symbol_valid, i_symbol_valid);
                        err_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        err_count++;
                    end
                    if (i_total_length !== want.total_length) begin
                        $error("total_length: expected %0d, actual %0d",
                               want.total_length, i_total_length);
                        err_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, i_last);
                        err_count++;
                    end
                    if (want.symbol_valid) begin
                        letter_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_numeral(i_number, i_capacity);
                item_count++;
            end
        end
        o_errors      <= err_count;
        o_pending     <= numeral_q.size();
        o_items       <= item_count;
        o_range_items <= range_count;
        o_cap_items   <= cap_count;
        o_letters     <= letter_count;
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the Roman numeral encoder: clock, reset, stimulus and verdict.
// Depends on rne_pkg, roman_numeral_encoder and roman_numeral_checker.
module tb;
    import rne_pkg::*;

    localparam int C_LONG_HOLD = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_number;
    logic        [7:0]  i_capacity;
    logic               o_out_valid;
    logic               i_out_ready;
    logic        [7:0]  o_symbol;
    logic               o_symbol_valid;
    logic        [1:0]  o_status;
    logic        [3:0]  o_total_length;
    logic               o_last;

    int errors;
    int pending;
    int items_done;
    int range_items;
    int cap_items;
    int letters_done;

    // Shared by both sides: percentage of idle cycles, and a counter that asks
    // the output side for one long hold-off each time it changes.
    int idle_pct  = 21;
    int hold_asks = 0;

    always #4 i_clk = ~i_clk;

    roman_numeral_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_number       (i_number),
        .i_capacity     (i_capacity),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_symbol       (o_symbol),
        .o_symbol_valid (o_symbol_valid),
        .o_status       (o_status),
        .o_total_length (o_total_length),
        .o_last         (o_last)
    );

    roman_numeral_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_number       (i_number),
        .i_capacity     (i_capacity),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_symbol       (o_symbol),
        .i_symbol_valid (o_symbol_valid),
        .i_status       (o_status),
        .i_total_length (o_total_length),
        .i_last         (o_last),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_items        (items_done),
        .o_range_items  (range_items),
        .o_cap_items    (cap_items),
        .o_letters      (letters_done)
    );

    task automatic send_number(input logic [15:0] num, input logic [7:0] cap);
        i_in_valid <= 1'b1;
        i_number   <= num;
        i_capacity <= cap;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_numbers(input int count);
        logic [15:0] num;
        logic [7:0]  cap;
        int          pick;
        int          n;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                num = 16'($urandom_range(65535));
            end else if (pick < 35) begin
                num = 16'($urandom_range(60));
            end else begin
                num = 16'($urandom_range(C_MAX_NUMBER));
            end
            // Mostly a roomy buffer, often one near the numeral's length.
            pick = $urandom_range(99);
            if (pick < 55) begin
                cap = 8'($urandom_range(16, 255));
            end else if (pick < 90) begin
                cap = 8'($urandom_range(16));
            end else begin
                cap = 8'($urandom_range(255));
            end
            send_number(num, cap);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : out_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = C_LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial begin : stimulus
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_number   <= '0;
        i_capacity <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero, the smallest buffers, every table step, exact fits and the limits.
        send_number(16'd0, 8'd0);
        send_number(16'd0, 8'd1);
        send_number(16'd0, 8'd255);
        send_number(16'd1, 8'd1);
        send_number(16'd1, 8'd2);
        send_number(16'd4, 8'd3);
        send_number(16'd9, 8'd3);
        send_number(16'd14, 8'd255);
        send_number(16'd40, 8'd3);
        send_number(16'd49, 8'd255);
        send_number(16'd90, 8'd255);
        send_number(16'd400, 8'd3);
        send_number(16'd444, 8'd255);
        send_number(16'd900, 8'd255);
        send_number(16'd1666, 8'd255);
        send_number(16'd1994, 8'd255);
        send_number(16'd3888, 8'd16);
        send_number(16'd3888, 8'd15);
        send_number(16'd3999, 8'd10);
        send_number(16'd3999, 8'd9);
        send_number(16'd3999, 8'd255);
        send_number(16'd4000, 8'd255);
        send_number(16'hFFFF, 8'd255);
        send_number(16'h8000, 8'd255);
        // The range check wins over an empty buffer.
        send_number(16'h7FFF, 8'd0);
        wait_drained();

        send_random_numbers(110);
        // The output side stalls for a long time while numbers keep coming.
        hold_asks <= hold_asks + 1;
        send_random_numbers(40);
        idle_pct <= 0;
        send_random_numbers(60);
        idle_pct <= 21;
        wait_drained();
        send_random_numbers(90);

        wait_drained();
        repeat (30) @(posedge i_clk);
        $display("Converted %0d numbers: %0d out of range, %0d too large for the buffer.",
                 items_done, range_items, cap_items);
        $display("Checked %0d letter transactions across idle, stalled and burst phases.",
                 letters_done);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $error("timeout with %0d results still expected", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
